/* hdl/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define A_HOLDS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define A_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* hdl/lapm_pkg.sv */
// types, constants and fixed point helpers for the look-at pose matrix block
package lapm_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int LEN_W  = DATA_W - 1;
  localparam int PROD_W = 2 * DATA_W;
  localparam int WIDE_W = DATA_W + FRAC_W;
  localparam int SQ_CNT_W  = $clog2(DATA_W);
  localparam int DIV_CNT_W = $clog2(WIDE_W);

  localparam logic signed [DATA_W-1:0] ONE  = DATA_W'(1) << FRAC_W;
  localparam logic signed [DATA_W-1:0] DMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DMIN = {1'b1, {(DATA_W-1){1'b0}}};

  // register indexes of the configuration port
  localparam logic [1:0] REG_UP_X    = 2'd0;
  localparam logic [1:0] REG_UP_Y    = 2'd1;
  localparam logic [1:0] REG_UP_Z    = 2'd2;
  localparam logic [1:0] REG_MIN_LEN = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] pos_w;
    logic signed [DATA_W-1:0] tgt_x;
    logic signed [DATA_W-1:0] tgt_y;
    logic signed [DATA_W-1:0] tgt_z;
    logic signed [DATA_W-1:0] tgt_w;
  } lapm_in_t;

  typedef struct packed {
    logic [1:0]               column;
    logic signed [DATA_W-1:0] elem0;
    logic signed [DATA_W-1:0] elem1;
    logic signed [DATA_W-1:0] elem2;
    logic signed [DATA_W-1:0] elem3;
    logic                     is_last;
    logic                     degenerate;
  } lapm_out_t;

  // queued item with its classification
  typedef struct packed {
    lapm_in_t data;
    logic     pw_zero;
    logic     pw_neg;
  } lapm_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] up_x;
    logic signed [DATA_W-1:0] up_y;
    logic signed [DATA_W-1:0] up_z;
    logic [LEN_W-1:0]         min_len;
  } lapm_cfg_t;

  // magnitude of a signed value as unsigned
  function automatic logic [DATA_W-1:0] qmag(logic signed [DATA_W-1:0] x);
    logic [DATA_W-1:0] r;
    r = x[DATA_W-1] ? DATA_W'(~x) + DATA_W'(1) : DATA_W'(x);
    return r;
  endfunction

  // apply sign to a wide magnitude and saturate
  function automatic logic signed [DATA_W-1:0] sat_q(logic neg, logic [WIDE_W-1:0] m);
    logic [WIDE_W-1:0] limit;
    logic signed [DATA_W-1:0] r;
    limit = neg ? WIDE_W'(DMAX) + WIDE_W'(1) : WIDE_W'(DMAX);
    if (m > limit) begin
      r = neg ? DMIN : DMAX;
    end else if (neg) begin
      r = DATA_W'(~m[DATA_W-1:0]) + DATA_W'(1);
    end else begin
      r = m[DATA_W-1:0];
    end
    return r;
  endfunction

  // saturating difference
  function automatic logic signed [DATA_W-1:0] qsub(logic signed [DATA_W-1:0] a,
                                                    logic signed [DATA_W-1:0] b);
    logic [DATA_W:0] d;
    logic signed [DATA_W-1:0] r;
    d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (d[DATA_W] != d[DATA_W-1]) begin
      r = d[DATA_W] ? DMIN : DMAX;
    end else begin
      r = d[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/lapm_front.sv */
// front end: accepts items, classifies the position w and queues them
module lapm_front import lapm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lapm_in_t   in_data_i,
  output logic       q_valid_o,
  output lapm_item_t q_item_o,
  input  logic       q_pop_i
);

  lapm_item_t ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = ent_q[rd_ptr_q];

  // classification and storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q].data    <= in_data_i;
      ent_q[wr_ptr_q].pw_zero <= (in_data_i.pos_w == '0);
      ent_q[wr_ptr_q].pw_neg  <= in_data_i.pos_w[DATA_W-1];
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

/* hdl/lapm_sqrt.sv */
// bit-serial integer square root, two radicand bits per cycle
module lapm_sqrt import lapm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] rad_i,
  output logic              done_o,
  output logic [DATA_W-1:0] root_o
);

  logic                 run_q, done_q;
  logic [SQ_CNT_W-1:0]  cnt_q;
  logic [PROD_W-1:0]    rad_q;
  logic [DATA_W+2:0]    rem_q, rem_sh, trial;
  logic [DATA_W-1:0]    root_q;
  logic                 ge;

  assign rem_sh = {rem_q[DATA_W:0], rad_q[PROD_W-1:PROD_W-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign done_o = done_q;
  assign root_o = root_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == '0);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= SQ_CNT_W'(DATA_W - 1);
      end else if (run_q) begin
        if (cnt_q == '0) run_q <= 1'b0;
        cnt_q <= cnt_q - SQ_CNT_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[PROD_W-3:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[DATA_W-2:0], ge};
    end
  end

endmodule

/* hdl/lapm_div.sv */
// bit-serial restoring divider for fixed point quotients
module lapm_div import lapm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] num_i,
  input  logic [DATA_W-1:0] den_i,
  output logic              done_o,
  output logic [WIDE_W-1:0] quo_o
);

  logic                 run_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [WIDE_W-1:0]    dvd_q, quo_q;
  logic [DATA_W-1:0]    rem_q, den_q;
  logic [DATA_W:0]      rem_sh, rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_q, dvd_q[WIDE_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = (rem_sh >= {1'b0, den_q});
  assign done_o  = done_q;
  assign quo_o   = quo_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == '0);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= DIV_CNT_W'(WIDE_W - 1);
      end else if (run_q) begin
        if (cnt_q == '0) run_q <= 1'b0;
        cnt_q <= cnt_q - DIV_CNT_W'(1);
      end
    end
  end

  // numerator is shifted up by the fraction width on load
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_i, {FRAC_W{1'b0}}};
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[WIDE_W-2:0], 1'b0};
      rem_q <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo_q <= {quo_q[WIDE_W-2:0], ge};
    end
  end

endmodule

/* hdl/lapm_back.sv */
// back end: sequences the products, lengths and quotients and emits columns
module lapm_back import lapm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  lapm_item_t q_item_i,
  output logic       q_pop_o,
  input  lapm_cfg_t  cfg_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output lapm_out_t  out_data_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PROD  = 3'd1;
  localparam logic [2:0] ST_SQ    = 3'd2;
  localparam logic [2:0] ST_ROOT  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_WAITD = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;
  localparam logic [2:0] ST_IDENT = 3'd7;

  localparam logic [1:0] STG_F = 2'd0;
  localparam logic [1:0] STG_S = 2'd1;
  localparam logic [1:0] STG_U = 2'd2;

  localparam logic [1:0] COL_SIDE = 2'd0;
  localparam logic [1:0] COL_UP   = 2'd1;
  localparam logic [1:0] COL_FWD  = 2'd2;
  localparam logic [1:0] COL_TRAN = 2'd3;

  function automatic logic signed [DATA_W-1:0] pick3(logic signed [DATA_W-1:0] v0,
                                                     logic signed [DATA_W-1:0] v1,
                                                     logic signed [DATA_W-1:0] v2,
                                                     logic [1:0] idx);
    logic signed [DATA_W-1:0] r;
    unique case (idx)
      2'd0:    r = v0;
      2'd1:    r = v1;
      default: r = v2;
    endcase
    return r;
  endfunction

  logic [2:0]  state_q;
  logic [1:0]  stage_q, comp_q, ph_q, col_q;
  lapm_item_t  item_q;
  logic signed [DATA_W-1:0] f_q [3];
  logic signed [DATA_W-1:0] s_q [3];
  logic signed [DATA_W-1:0] u_q [3];
  logic signed [DATA_W-1:0] res_q [3];
  logic [DATA_W-1:0] lf_q, ls_q, lu_q;
  logic [PROD_W-1:0] prod_q, acc_q;
  logic              pneg_q, div_neg_q;
  logic signed [DATA_W-1:0] q1_q;
  logic              out_valid_q;
  lapm_out_t         out_q;

  lapm_in_t                 it;
  logic [1:0]               i_nx, i_pv;
  logic signed [DATA_W-1:0] mul_a, mul_b, cur_v, prod_fix;
  logic                     sq_done, dv_done, sq_start, dv_start;
  logic [DATA_W-1:0]        root;
  logic [WIDE_W-1:0]        quo;
  logic signed [DATA_W-1:0] num;
  logic [DATA_W-1:0]        den;
  logic                     num_neg, direct;
  logic signed [DATA_W-1:0] direct_v;
  logic                     out_free;

  assign it       = item_q.data;
  assign i_nx     = (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
  assign i_pv     = (comp_q == 2'd0) ? 2'd2 : comp_q - 2'd1;
  assign prod_fix = sat_q(pneg_q, prod_q[FRAC_W +: WIDE_W]);
  assign out_free = !out_valid_q || out_ready_i;
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;

  // component of the vector whose length is being taken
  always_comb begin
    unique case (stage_q)
      STG_F:   cur_v = pick3(f_q[0], f_q[1], f_q[2], ph_q);
      STG_S:   cur_v = pick3(s_q[0], s_q[1], s_q[2], ph_q);
      default: cur_v = pick3(u_q[0], u_q[1], u_q[2], ph_q);
    endcase
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    priority if (state_q == ST_PROD) begin
      unique case (stage_q)
        STG_F: begin
          mul_a = (ph_q == 2'd0) ? pick3(it.tgt_x, it.tgt_y, it.tgt_z, comp_q)
                                 : pick3(it.pos_x, it.pos_y, it.pos_z, comp_q);
          mul_b = (ph_q == 2'd0) ? it.pos_w : it.tgt_w;
        end
        STG_S: begin
          mul_a = (ph_q == 2'd0) ? pick3(cfg_i.up_x, cfg_i.up_y, cfg_i.up_z, i_nx)
                                 : pick3(cfg_i.up_x, cfg_i.up_y, cfg_i.up_z, i_pv);
          mul_b = (ph_q == 2'd0) ? pick3(f_q[0], f_q[1], f_q[2], i_pv)
                                 : pick3(f_q[0], f_q[1], f_q[2], i_nx);
        end
        default: begin
          mul_a = (ph_q == 2'd0) ? pick3(f_q[0], f_q[1], f_q[2], i_nx)
                                 : pick3(f_q[0], f_q[1], f_q[2], i_pv);
          mul_b = (ph_q == 2'd0) ? pick3(s_q[0], s_q[1], s_q[2], i_pv)
                                 : pick3(s_q[0], s_q[1], s_q[2], i_nx);
        end
      endcase
    end else if (state_q == ST_SQ) begin
      mul_a = cur_v;
      mul_b = cur_v;
    end else begin
      mul_a = '0;
      mul_b = '0;
    end
  end

  // shared multiplier, registered
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(qmag(mul_a)) * PROD_W'(qmag(mul_b));
    pneg_q <= mul_a[DATA_W-1] ^ mul_b[DATA_W-1];
  end

  // quotient operand selection
  always_comb begin
    unique case (col_q)
      COL_SIDE: begin
        num = pick3(s_q[0], s_q[1], s_q[2], comp_q);
        den = ls_q;
      end
      COL_UP: begin
        num = pick3(u_q[0], u_q[1], u_q[2], comp_q);
        den = lu_q;
      end
      COL_FWD: begin
        num = pick3(f_q[0], f_q[1], f_q[2], comp_q);
        den = lf_q;
      end
      default: begin
        num = pick3(it.pos_x, it.pos_y, it.pos_z, comp_q);
        den = qmag(it.pos_w);
      end
    endcase
    num_neg  = num[DATA_W-1] ^ ((col_q == COL_TRAN) && item_q.pw_neg);
    direct   = (col_q == COL_TRAN) && item_q.pw_zero;
    direct_v = (num == '0) ? '0 : (num[DATA_W-1] ? DMIN : DMAX);
  end

  assign sq_start = (state_q == ST_SQ) && (ph_q == 2'd3);
  assign dv_start = (state_q == ST_DIV) && !direct;

  lapm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (acc_q + prod_q),
    .done_o  (sq_done),
    .root_o  (root)
  );

  lapm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (qmag(num)),
    .den_i   (den),
    .done_o  (dv_done),
    .quo_o   (quo)
  );

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) item_q <= q_item_i;
    if (state_q == ST_PROD && ph_q == 2'd1) q1_q <= prod_fix;
    if (state_q == ST_PROD && ph_q == 2'd2) begin
      unique case (stage_q)
        STG_F:   f_q[comp_q] <= qsub(q1_q, prod_fix);
        STG_S:   s_q[comp_q] <= qsub(q1_q, prod_fix);
        default: u_q[comp_q] <= qsub(q1_q, prod_fix);
      endcase
    end
    if (state_q == ST_SQ && ph_q == 2'd1) acc_q <= prod_q;
    if (state_q == ST_SQ && ph_q == 2'd2) acc_q <= acc_q + prod_q;
    if (state_q == ST_ROOT && sq_done) begin
      unique case (stage_q)
        STG_F:   lf_q <= root;
        STG_S:   ls_q <= root;
        default: lu_q <= root;
      endcase
    end
    if (state_q == ST_DIV) begin
      div_neg_q <= num_neg;
      if (direct) res_q[comp_q] <= direct_v;
    end
    if (state_q == ST_WAITD && dv_done) res_q[comp_q] <= sat_q(div_neg_q, quo);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= STG_F;
      comp_q  <= 2'd0;
      ph_q    <= 2'd0;
      col_q   <= COL_SIDE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            state_q <= ST_PROD;
            stage_q <= STG_F;
            comp_q  <= 2'd0;
            ph_q    <= 2'd0;
          end
        end
        ST_PROD: begin
          if (ph_q == 2'd2) begin
            ph_q <= 2'd0;
            if (comp_q == 2'd2) begin
              comp_q  <= 2'd0;
              state_q <= ST_SQ;
            end else begin
              comp_q <= comp_q + 2'd1;
            end
          end else begin
            ph_q <= ph_q + 2'd1;
          end
        end
        ST_SQ: begin
          ph_q <= ph_q + 2'd1;
          if (ph_q == 2'd3) state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          if (sq_done) begin
            ph_q <= 2'd0;
            if (root == '0 || root < {1'b0, cfg_i.min_len}) begin
              state_q <= ST_IDENT;
              col_q   <= COL_SIDE;
            end else if (stage_q == STG_U) begin
              state_q <= ST_DIV;
              col_q   <= COL_SIDE;
              comp_q  <= 2'd0;
            end else begin
              state_q <= ST_PROD;
              stage_q <= stage_q + 2'd1;
              comp_q  <= 2'd0;
            end
          end
        end
        ST_DIV: begin
          if (!direct) begin
            state_q <= ST_WAITD;
          end else if (comp_q == 2'd2) begin
            comp_q  <= 2'd0;
            state_q <= ST_EMIT;
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        ST_WAITD: begin
          if (dv_done) begin
            if (comp_q == 2'd2) begin
              comp_q  <= 2'd0;
              state_q <= ST_EMIT;
            end else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= ST_DIV;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (col_q == COL_TRAN) begin
              state_q <= ST_IDLE;
            end else begin
              col_q   <= col_q + 2'd1;
              state_q <= ST_DIV;
            end
          end
        end
        default: begin
          if (out_free) begin
            if (col_q == COL_TRAN) state_q <= ST_IDLE;
            else                   col_q   <= col_q + 2'd1;
          end
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_EMIT || state_q == ST_IDENT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      out_q.column     <= col_q;
      out_q.elem0      <= res_q[0];
      out_q.elem1      <= res_q[1];
      out_q.elem2      <= res_q[2];
      out_q.elem3      <= (col_q == COL_TRAN) ? ONE : '0;
      out_q.is_last    <= (col_q == COL_TRAN);
      out_q.degenerate <= 1'b0;
    end else if (state_q == ST_IDENT && out_free) begin
      out_q.column     <= col_q;
      out_q.elem0      <= (col_q == COL_SIDE) ? ONE : '0;
      out_q.elem1      <= (col_q == COL_UP)   ? ONE : '0;
      out_q.elem2      <= (col_q == COL_FWD)  ? ONE : '0;
      out_q.elem3      <= (col_q == COL_TRAN) ? ONE : '0;
      out_q.is_last    <= (col_q == COL_TRAN);
      out_q.degenerate <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/look_at_pose_matrix.sv */
// Look-at pose matrix: each accepted position/target item yields four column
// items (side, up, forward, translation) in Q15.16. An item takes longer when
// the matrix is built than when an axis is short and the identity is given;
// the time is set by the shared 32x32 multiplier, the square root unit (two
// radicand bits per cycle, three lengths) and the restoring divider (one
// quotient bit per cycle, 48 bits, up to twelve quotients). A two-item queue
// lets the next items be taken while one is worked on, and the output register
// lets the back end finish a column while the last one waits. Configuration
// writes are taken at any cycle and must be made idle.
`include "assert_macros.svh"

module look_at_pose_matrix import lapm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lapm_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lapm_out_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i
);

  lapm_cfg_t  cfg_q;
  logic       q_valid, q_pop;
  lapm_item_t q_item;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.up_x    <= '0;
      cfg_q.up_y    <= ONE;
      cfg_q.up_z    <= '0;
      cfg_q.min_len <= LEN_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_UP_X: cfg_q.up_x    <= cfg_data_i;
        REG_UP_Y: cfg_q.up_y    <= cfg_data_i;
        REG_UP_Z: cfg_q.up_z    <= cfg_data_i;
        default:  cfg_q.min_len <= cfg_data_i[LEN_W-1:0];
      endcase
    end
  end

  lapm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  lapm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // last flag marks the translation column only
  `A_HOLDS(a_last_col, out_valid_o |-> (out_data_o.is_last == (out_data_o.column == 2'd3)))
  // columns of one matrix follow in order
  `A_HOLDS(a_col_order, (out_valid_o && out_ready_i && !out_data_o.is_last) |=> (!out_valid_o || out_data_o.column == $past(out_data_o.column) + 2'd1))
  // translation column always carries one in the bottom row
  `A_NEVER(a_last_w, out_valid_o && out_data_o.is_last && out_data_o.elem3 != ONE)

endmodule

/* tb/sv/look_at_pose_matrix_test.sv */
// testbench for the look-at pose matrix block: directed and random items checked against a built-in predictor
`timescale 1ns / 1ps

module look_at_pose_matrix_test;
  import lapm_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  lapm_in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  lapm_out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [DATA_W-1:0] cfg_data_i;

  look_at_pose_matrix u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  typedef logic signed [63:0] wval_t;

  // predictor copy of the registers
  logic signed [DATA_W-1:0] up_vec [3];
  logic [LEN_W-1:0] min_len;

  lapm_in_t pose_q[$];
  lapm_out_t column_q[$];
  int fail_cnt;
  int items_sent;
  int columns_seen;
  int degen_seen;
  int send_gap;
  int recv_gap;
  int calm_left;

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #20ms;
    $display("look_at_pose_matrix: mismatch");
    $finish;
  end

  // idle lengths: mostly short, a few long, with calm stretches
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 40) == 0) calm_left = $urandom_range(10, 40);
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // fixed point helpers
  function automatic logic [63:0] abs_of(wval_t x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic wval_t clamp_q(bit neg, logic [127:0] m);
    logic [127:0] lim;
    logic [DATA_W-1:0] low;
    lim = 128'(DMAX) + (neg ? 128'd1 : 128'd0);
    if (m > lim) return neg ? wval_t'(DMIN) : wval_t'(DMAX);
    low = m[DATA_W-1:0];
    if (neg) low = -low;
    return wval_t'(signed'(low));
  endfunction

  function automatic wval_t fx_mul(wval_t a, wval_t b);
    logic [127:0] m;
    m = (128'(abs_of(a)) * 128'(abs_of(b))) >> FRAC_W;
    return clamp_q((a < 0) != (b < 0), m);
  endfunction

  function automatic wval_t fx_sub(wval_t a, wval_t b);
    wval_t d;
    d = a - b;
    if (d > wval_t'(DMAX)) return wval_t'(DMAX);
    if (d < wval_t'(DMIN)) return wval_t'(DMIN);
    return d;
  endfunction

  function automatic wval_t fx_div(wval_t num, bit dneg, logic [63:0] d);
    logic [127:0] q;
    q = (128'(abs_of(num)) << FRAC_W) / 128'(d);
    return clamp_q((num < 0) != dneg, q);
  endfunction

  function automatic logic [63:0] axis_len(wval_t v [3]);
    logic [127:0] sq;
    logic [63:0] r;
    logic [63:0] c;
    sq = 128'(abs_of(v[0])) * 128'(abs_of(v[0])) + 128'(abs_of(v[1])) * 128'(abs_of(v[1]))
       + 128'(abs_of(v[2])) * 128'(abs_of(v[2]));
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= sq) r = c;
    end
    return r;
  endfunction

  function automatic void cross3(wval_t a [3], wval_t b [3], output wval_t r [3]);
    r[0] = fx_sub(fx_mul(a[1], b[2]), fx_mul(a[2], b[1]));
    r[1] = fx_sub(fx_mul(a[2], b[0]), fx_mul(a[0], b[2]));
    r[2] = fx_sub(fx_mul(a[0], b[1]), fx_mul(a[1], b[0]));
  endfunction

  // work out the four columns of the pose for one item
  task automatic push_pose_columns(lapm_in_t d);
    wval_t p [4];
    wval_t t [4];
    wval_t upv [3];
    wval_t f [3];
    wval_t s [3];
    wval_t u [3];
    wval_t m [4][4];
    logic [63:0] lf, ls, lu;
    bit degen;
    lapm_out_t col;
    p = '{wval_t'(d.pos_x), wval_t'(d.pos_y), wval_t'(d.pos_z), wval_t'(d.pos_w)};
    t = '{wval_t'(d.tgt_x), wval_t'(d.tgt_y), wval_t'(d.tgt_z), wval_t'(d.tgt_w)};
    for (int i = 0; i < 3; i++) upv[i] = wval_t'(up_vec[i]);
    for (int i = 0; i < 3; i++) f[i] = fx_sub(fx_mul(t[i], p[3]), fx_mul(p[i], t[3]));
    lf = axis_len(f);
    ls = '0;
    lu = '0;
    degen = lf < 64'(min_len);
    if (!degen) begin
      cross3(upv, f, s);
      ls = axis_len(s);
      degen = ls < 64'(min_len);
    end
    if (!degen) begin
      cross3(f, s, u);
      lu = axis_len(u);
      degen = lu < 64'(min_len);
    end
    for (int k = 0; k < 4; k++)
      for (int i = 0; i < 4; i++) m[k][i] = 0;
    if (degen || lf == 0 || ls == 0 || lu == 0) begin
      degen = 1'b1;
      for (int k = 0; k < 4; k++) m[k][k] = wval_t'(ONE);
    end else begin
      for (int i = 0; i < 3; i++) begin
        m[0][i] = fx_div(s[i], 1'b0, ls);
        m[1][i] = fx_div(u[i], 1'b0, lu);
        m[2][i] = fx_div(f[i], 1'b0, lf);
        if (p[3] == 0)
          m[3][i] = p[i] == 0 ? 0 : (p[i] > 0 ? wval_t'(DMAX) : wval_t'(DMIN));
        else
          m[3][i] = fx_div(p[i], p[3] < 0, abs_of(p[3]));
      end
      m[3][3] = wval_t'(ONE);
    end
    for (int k = 0; k < 4; k++) begin
      col.column = 2'(k);
      col.elem0 = m[k][0][DATA_W-1:0];
      col.elem1 = m[k][1][DATA_W-1:0];
      col.elem2 = m[k][2][DATA_W-1:0];
      col.elem3 = m[k][3][DATA_W-1:0];
      col.is_last = (k == 3);
      col.degenerate = degen;
      column_q.push_back(col);
    end
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      send_gap <= 0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (in_valid_i) begin
        push_pose_columns(in_data_i);
        items_sent++;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pose_q.size() > 0) begin
        in_data_i <= pose_q.pop_front();
        in_valid_i <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output monitor and back pressure
  always @(posedge clk_i or negedge rst_ni) begin
    lapm_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        columns_seen++;
        if (column_q.size() == 0) begin
          $error("unexpected column item %0d", out_data_o.column);
          fail_cnt++;
        end else begin
          want = column_q.pop_front();
          if (out_data_o.degenerate && out_data_o.is_last) degen_seen++;
          if (out_data_o.column !== want.column) begin
            $error("column: expected %0d, got %0d", want.column, out_data_o.column);
            fail_cnt++;
          end
          if (out_data_o.elem0 !== want.elem0) begin
            $error("elem0: expected %h, got %h", want.elem0, out_data_o.elem0);
            fail_cnt++;
          end
          if (out_data_o.elem1 !== want.elem1) begin
            $error("elem1: expected %h, got %h", want.elem1, out_data_o.elem1);
            fail_cnt++;
          end
          if (out_data_o.elem2 !== want.elem2) begin
            $error("elem2: expected %h, got %h", want.elem2, out_data_o.elem2);
            fail_cnt++;
          end
          if (out_data_o.elem3 !== want.elem3) begin
            $error("elem3: expected %h, got %h", want.elem3, out_data_o.elem3);
            fail_cnt++;
          end
          if (out_data_o.is_last !== want.is_last) begin
            $error("is_last: expected %0b, got %0b", want.is_last, out_data_o.is_last);
            fail_cnt++;
          end
          if (out_data_o.degenerate !== want.degenerate) begin
            $error("degenerate: expected %0b, got %0b", want.degenerate,
                   out_data_o.degenerate);
            fail_cnt++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  // register write, only while idle
  task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_UP_X:    up_vec[0] = val;
      REG_UP_Y:    up_vec[1] = val;
      REG_UP_Z:    up_vec[2] = val;
      REG_MIN_LEN: min_len = val[LEN_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (pose_q.size() == 0 && !in_valid_i && column_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic lapm_in_t make_pose(logic [DATA_W-1:0] px, logic [DATA_W-1:0] py,
                                         logic [DATA_W-1:0] pz, logic [DATA_W-1:0] pw,
                                         logic [DATA_W-1:0] tx, logic [DATA_W-1:0] ty,
                                         logic [DATA_W-1:0] tz, logic [DATA_W-1:0] tw);
    lapm_in_t d;
    d.pos_x = px; d.pos_y = py; d.pos_z = pz; d.pos_w = pw;
    d.tgt_x = tx; d.tgt_y = ty; d.tgt_z = tz; d.tgt_w = tw;
    return d;
  endfunction

  function automatic logic [DATA_W-1:0] coord(int span);
    return DATA_W'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // signed random step scaled by one up component
  function automatic logic [DATA_W-1:0] up_step(logic signed [DATA_W-1:0] upc);
    logic signed [DATA_W-1:0] k;
    k = coord(1 << 18);
    return DATA_W'(fx_mul(wval_t'(upc), wval_t'(k)));
  endfunction

  // random items: mostly plausible scenes, some full range, some degenerate
  task automatic queue_random(int n);
    lapm_in_t d;
    int kind;
    logic [DATA_W-1:0] w;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        w = ($urandom_range(0, 3) == 0) ? coord(1 << 18) : ONE;
        d = make_pose(coord(1 << 21), coord(1 << 21), coord(1 << 21), w,
                      coord(1 << 21), coord(1 << 21), coord(1 << 21),
                      ($urandom_range(0, 3) == 0) ? coord(1 << 18) : ONE);
        if ($urandom_range(0, 7) == 0) d.pos_w = '0;
      end else if (kind < 8) begin
        d = make_pose($urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 9) begin
        // target on the eye point
        d = make_pose(coord(1 << 20), coord(1 << 20), coord(1 << 20), ONE, '0, '0, '0, ONE);
        d.tgt_x = d.pos_x; d.tgt_y = d.pos_y; d.tgt_z = d.pos_z;
        if ($urandom_range(0, 1)) d.tgt_x = d.tgt_x + DATA_W'($urandom_range(0, 3));
      end else begin
        // looking along the up direction
        d = make_pose(coord(1 << 20), coord(1 << 20), coord(1 << 20), ONE, '0, '0, '0, ONE);
        d.tgt_x = d.pos_x + up_step(up_vec[0]);
        d.tgt_y = d.pos_y + up_step(up_vec[1]);
        d.tgt_z = d.pos_z + up_step(up_vec[2]);
      end
      pose_q.push_back(d);
    end
  endtask

  // stimulus
  initial begin
    fail_cnt = 0;
    items_sent = 0;
    columns_seen = 0;
    degen_seen = 0;
    calm_left = 0;
    up_vec = '{'0, ONE, '0};
    min_len = LEN_W'(1);
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_UP_X;
    cfg_data_i = '0;
    wait (rst_ni);
    repeat (3) @(posedge clk_i);

    // directed corners at reset settings
    pose_q.push_back(make_pose('0, '0, '0, '0, '0, '0, '0, '0));
    pose_q.push_back(make_pose('0, '0, 5 * ONE, ONE, '0, '0, '0, ONE));
    pose_q.push_back(make_pose(ONE, 2 * ONE, 3 * ONE, ONE, -ONE, ONE, '0, ONE));
    pose_q.push_back(make_pose(2 * ONE, '0, 2 * ONE, 2 * ONE, '0, '0, '0, ONE));
    pose_q.push_back(make_pose(ONE, -ONE, ONE, -ONE, '0, '0, '0, ONE));
    pose_q.push_back(make_pose(3 * ONE, -ONE, '0, '0, '0, '0, ONE, ONE));
    pose_q.push_back(make_pose('0, '0, '0, '0, '0, '0, ONE, ONE));
    pose_q.push_back(make_pose('0, '0, '0, ONE, '0, 4 * ONE, '0, ONE));
    pose_q.push_back(make_pose(DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX));
    pose_q.push_back(make_pose(DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN));
    pose_q.push_back(make_pose(DMAX, DMIN, DMAX, ONE, DMIN, DMAX, DMIN, ONE));
    pose_q.push_back(make_pose(DMIN, DMAX, '0, DMIN, DMAX, '0, DMIN, DMAX));
    pose_q.push_back(make_pose(ONE, ONE, ONE, 1, '0, '0, '0, ONE));
    pose_q.push_back(make_pose(ONE, ONE, ONE, ONE, ONE, ONE, ONE + 1, ONE));
    pose_q.push_back(make_pose('1, '1, '1, '1, '1, '1, '1, '1));
    pose_q.push_back(make_pose(DMAX, 1, -1, DMIN, '0, DMIN, DMAX, -ONE));
    queue_random(90);
    wait_drained();

    // extreme up direction, no length limit
    write_reg(REG_UP_X, DMAX);
    write_reg(REG_UP_Y, DMIN);
    write_reg(REG_UP_Z, DATA_W'(1));
    write_reg(REG_MIN_LEN, '0);
    queue_random(45);
    wait_drained();

    // largest length limit: identity unless every axis is at least that long
    write_reg(REG_UP_X, '0);
    write_reg(REG_UP_Y, '0);
    write_reg(REG_UP_Z, ONE);
    write_reg(REG_MIN_LEN, DATA_W'(DMAX));
    queue_random(20);
    wait_drained();

    // tilted up, unit limit
    write_reg(REG_UP_X, ONE);
    write_reg(REG_UP_Y, ONE);
    write_reg(REG_UP_Z, -ONE);
    write_reg(REG_MIN_LEN, ONE);
    queue_random(50);
    wait_drained();

    // random up x, y and length limit, up z at its minimum
    write_reg(REG_UP_X, coord(1 << 17));
    write_reg(REG_UP_Y, coord(1 << 17));
    write_reg(REG_UP_Z, DMIN);
    write_reg(REG_MIN_LEN, DATA_W'($urandom_range(0, 1 << 14)));
    queue_random(30);
    wait_drained();
    repeat (800) @(posedge clk_i);

    $display("%0d poses sent over five register settings, %0d columns checked, %0d identity",
             items_sent, columns_seen, degen_seen);
    if (fail_cnt == 0 && column_q.size() == 0) begin
      $display("look_at_pose_matrix: match");
    end else begin
      $display("look_at_pose_matrix: mismatch");
    end
    $finish;
  end

endmodule

/* look_at_pose_matrix.f */
+incdir+hdl
hdl/lapm_pkg.sv
hdl/lapm_front.sv
hdl/lapm_sqrt.sv
hdl/lapm_div.sv
hdl/lapm_back.sv
hdl/look_at_pose_matrix.sv
tb/sv/look_at_pose_matrix_test.sv
